>>> rtl/cnms_pkg.sv
package cnms_pkg;

	// Build defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAG_BITS_DEF  = 16;

	// Fixed field widths and frame limits
	localparam int MAG_PORT_W = 16;
	localparam int MAX_HEIGHT = 4096;
	localparam int SCALE_W    = 24;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_DATA_W = 24;

	typedef logic [9:0]  px_t;
	typedef logic [11:0] py_t;
	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  dir_t;
	typedef logic [10:0] width_t;
	typedef logic [12:0] height_t;
	typedef logic [23:0] scale_t;

	// Register reset values
	localparam width_t  WIDTH_RST  = 11'd1024;
	localparam height_t HEIGHT_RST = 13'd1024;
	localparam scale_t  SCALE_RST  = 24'd256;
	localparam byte_t   LOW_RST    = 8'd0;
	localparam byte_t   HIGH_RST   = 8'd255;

	typedef enum logic [2:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_NORM_SCALE   = 3'd2,
		CFG_LEVEL_LOW    = 3'd3,
		CFG_LEVEL_HIGH   = 3'd4
	} cfg_idx_t;

	// Gradient direction codes; anything above DIR_DIAG_L means no direction
	typedef enum logic [2:0] {
		DIR_VERT   = 3'd0,
		DIR_HORZ   = 3'd1,
		DIR_DIAG_R = 3'd2,
		DIR_DIAG_L = 3'd3,
		DIR_NONE   = 3'd4
	} dir_code_t;

	typedef enum logic [1:0] {
		CLASS_NONE   = 2'd0,
		CLASS_WEAK   = 2'd1,
		CLASS_STRONG = 2'd2
	} class_t;

	// Position of an incoming pixel plus its border flags
	typedef struct packed {
		px_t  x;
		py_t  y;
		logic x_is0;
		logic x_is1;
		logic y_is0;
		logic y_is1;
		logic row_end;
		logic last_row;
	} pos_t;

	// One centre pixel after suppression, before scaling
	typedef struct packed {
		px_t  cx;
		py_t  cy;
		logic pass;
		logic run_last;
		logic frame_last;
	} cand_t;

	typedef struct packed {
		px_t    pixel_x;
		py_t    pixel_y;
		byte_t  edge_value;
		class_t edge_class;
		logic   run_last;
		logic   frame_last;
	} result_t;

endpackage

>>> rtl/cnms_line_mem.sv
module cnms_line_mem #(
	parameter int DEPTH = cnms_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(cnms_pkg::MAX_WIDTH_DEF),
	parameter int WW    = 2 * cnms_pkg::MAG_BITS_DEF + 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [WW-1:0] wr_data,
	output logic [WW-1:0] rd_data
);

	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_word_q;
	logic [AW-1:0] rd_addr_q;
	logic          lastw_v_q;
	logic [AW-1:0] lastw_addr_q;
	logic [WW-1:0] lastw_data_q;

	// Column entry: both magnitude banks and the previous row's direction
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Remember the latest write for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastw_v_q <= 1'b0;
		end else if (wr_en) begin
			lastw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lastw_addr_q <= wr_addr;
			lastw_data_q <= wr_data;
		end
	end

	// Forward the write that raced the read of the same column
	assign rd_data = (lastw_v_q && lastw_addr_q == rd_addr_q) ? lastw_data_q : rd_word_q;

	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en && rd_addr == wr_addr) |=> (rd_data == $past(wr_data)))
		else $error("line buffer read missed a write to the same column");

endmodule

>>> rtl/cnms_window.sv
module cnms_window #(
	parameter int MW = cnms_pkg::MAG_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  cnms_pkg::pos_t       pos,
	input  logic [MW-1:0]        top_val,
	input  logic [MW-1:0]        mid_val,
	input  logic [MW-1:0]        bot_val,
	input  cnms_pkg::dir_t       dir_mid,
	input  cnms_pkg::dir_t       dir_bot,
	output logic                 take,
	input  logic                 cand_ready,
	output logic                 cand_valid,
	output cnms_pkg::cand_t      cand,
	output logic [MW-1:0]        cand_mag
);

	logic [2:0][2:0][MW-1:0]      win_q;
	logic [1:0][1:0][2:0]         dwin_q;
	logic [3:0]                   mask_q;
	cnms_pkg::pos_t               pos_s2;
	logic                         cand_v_s3;
	cnms_pkg::cand_t              cand_s3;
	logic [MW-1:0]                mag_s3;

	logic [3:0]                   new_mask;
	logic [3:0]                   slot_oh;
	logic [1:0]                   slot;
	logic                         cand_free;
	logic                         issue;
	logic                         last_one;
	logic                         cc2;
	logic                         cr2;
	logic [1:0]                   cc;
	logic [1:0]                   cr;
	logic [1:0]                   lc;
	logic [1:0]                   rc;
	logic [1:0]                   ar;
	logic [1:0]                   br;
	logic                         left_e;
	logic                         top_e;
	logic [MW-1:0]                cval;
	logic [MW-1:0]                n1;
	logic [MW-1:0]                n2;
	logic                         keep;
	cnms_pkg::dir_t               dsel;
	cnms_pkg::cand_t              cand_nx;

	function automatic logic [MW-1:0] pick(input logic [2:0][2:0][MW-1:0] w,
		input logic [1:0] r, input logic [1:0] c);
		logic [MW-1:0] v;
		case ({r, c})
			4'b0000: v = w[0][0];
			4'b0001: v = w[0][1];
			4'b0010: v = w[0][2];
			4'b0100: v = w[1][0];
			4'b0101: v = w[1][1];
			4'b0110: v = w[1][2];
			4'b1000: v = w[2][0];
			4'b1001: v = w[2][1];
			4'b1010: v = w[2][2];
			default: v = '0;
		endcase
		return v;
	endfunction

	// Results owed by the new pixel: centres of the previous column, then this one
	assign new_mask[0] = !pos.x_is0 && !pos.y_is0;
	assign new_mask[1] = !pos.x_is0 && pos.last_row;
	assign new_mask[2] = pos.row_end && !pos.y_is0;
	assign new_mask[3] = pos.row_end && pos.last_row;

	// Pick the lowest pending result
	assign slot_oh   = mask_q & (~mask_q + 4'd1);
	assign slot      = {slot_oh[3] | slot_oh[2], slot_oh[3] | slot_oh[1]};
	assign cand_free = !cand_v_s3 || cand_ready;
	assign issue     = (mask_q != 4'd0) && cand_free;
	assign last_one  = (mask_q & (mask_q - 4'd1)) == 4'd0;
	assign take      = (mask_q == 4'd0) || (issue && last_one);

	// Window coordinates of the centre and its replicated neighbors
	always_comb begin
		cc2    = slot[1];
		cr2    = slot[0];
		cc     = {cc2, ~cc2};
		cr     = {cr2, ~cr2};
		left_e = cc2 ? pos_s2.x_is0 : pos_s2.x_is1;
		top_e  = cr2 ? pos_s2.y_is0 : pos_s2.y_is1;
		lc     = left_e ? cc : cc - 2'd1;
		rc     = cc2 ? cc : cc + 2'd1;
		ar     = top_e ? cr : cr - 2'd1;
		br     = cr2 ? cr : cr + 2'd1;
		cval   = pick(win_q, cr, cc);
		case (slot)
			2'd0:    dsel = dwin_q[0][0];
			2'd1:    dsel = dwin_q[1][0];
			2'd2:    dsel = dwin_q[0][1];
			default: dsel = dwin_q[1][1];
		endcase
	end

	// Neighbors along the gradient direction
	always_comb begin
		keep = 1'b1;
		n1   = '0;
		n2   = '0;
		case (cnms_pkg::dir_code_t'(dsel))
			cnms_pkg::DIR_VERT: begin
				n1 = pick(win_q, br, cc);
				n2 = pick(win_q, ar, cc);
			end
			cnms_pkg::DIR_HORZ: begin
				n1 = pick(win_q, cr, rc);
				n2 = pick(win_q, cr, lc);
			end
			cnms_pkg::DIR_DIAG_R: begin
				n1 = pick(win_q, br, rc);
				n2 = pick(win_q, ar, lc);
			end
			cnms_pkg::DIR_DIAG_L: begin
				n1 = pick(win_q, ar, rc);
				n2 = pick(win_q, br, lc);
			end
			default: keep = 1'b0;
		endcase
	end

	always_comb begin
		cand_nx.cx         = cc2 ? pos_s2.x : pos_s2.x - 10'd1;
		cand_nx.cy         = cr2 ? pos_s2.y : pos_s2.y - 12'd1;
		cand_nx.pass       = keep && (n1 <= cval) && (n2 <= cval);
		cand_nx.run_last   = last_one;
		cand_nx.frame_last = cc2 && cr2;
	end

	// Shift the window one column when a pixel enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			dwin_q <= '0;
		end else if (load) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2]  <= top_val;
			win_q[1][2]  <= mid_val;
			win_q[2][2]  <= bot_val;
			dwin_q[0][0] <= dwin_q[0][1];
			dwin_q[1][0] <= dwin_q[1][1];
			dwin_q[0][1] <= dir_mid;
			dwin_q[1][1] <= dir_bot;
		end
	end

	// Pending results of the pixel in the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 4'd0;
		end else if (load) begin
			mask_q <= new_mask;
		end else if (issue) begin
			mask_q <= mask_q & ~slot_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_s2 <= pos;
		end
	end

	// Candidate register toward scaling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_v_s3 <= 1'b0;
		end else if (cand_free) begin
			cand_v_s3 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cand_s3 <= cand_nx;
			mag_s3  <= cval;
		end
	end

	assign cand_valid = cand_v_s3;
	assign cand       = cand_s3;
	assign cand_mag   = mag_s3;

	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cand_v_s3 && cand_s3.frame_last) |-> cand_s3.run_last)
		else $error("frame end result is not the last of its pixel");

	a_no_shift_mid_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(load && mask_q != 4'd0) |-> (issue && last_one))
		else $error("window shifted while results were still owed");

endmodule

>>> rtl/cnms_classify.sv
module cnms_classify #(
	parameter int MW = cnms_pkg::MAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cnms_pkg::scale_t      norm_scale,
	input  cnms_pkg::byte_t       level_low,
	input  cnms_pkg::byte_t       level_high,
	input  logic                  cand_valid,
	input  cnms_pkg::cand_t       cand,
	input  logic [MW-1:0]         cand_mag,
	output logic                  cand_ready,
	output logic                  res_valid,
	input  logic                  res_stall,
	output cnms_pkg::result_t     res
);

	localparam int PW = MW + cnms_pkg::SCALE_W;
	localparam int FB = cnms_pkg::FRAC_BITS;

	logic                 v_s4;
	logic [PW-1:0]        prod_s4;
	cnms_pkg::cand_t      info_s4;
	logic                 out_v_q;
	cnms_pkg::result_t    out_q;
	logic                 skid_v_q;
	cnms_pkg::result_t    skid_q;

	logic                 free4;
	logic                 push;
	logic                 out_take;
	cnms_pkg::byte_t      sat;
	cnms_pkg::result_t    res_nx;

	assign free4      = !v_s4 || !skid_v_q;
	assign cand_ready = free4;
	assign push       = v_s4 && !skid_v_q;
	assign out_take   = out_v_q && !res_stall;

	// Scale the candidate's magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (free4) begin
			v_s4 <= cand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free4 && cand_valid) begin
			prod_s4 <= PW'(cand_mag) * PW'(norm_scale);
			info_s4 <= cand;
		end
	end

	// Saturate to a byte and class it against the levels
	always_comb begin
		sat = (|prod_s4[PW-1:FB+8]) ? 8'hFF : prod_s4[FB+7:FB];
		res_nx.pixel_x    = info_s4.cx;
		res_nx.pixel_y    = info_s4.cy;
		res_nx.run_last   = info_s4.run_last;
		res_nx.frame_last = info_s4.frame_last;
		res_nx.edge_value = 8'd0;
		res_nx.edge_class = cnms_pkg::CLASS_NONE;
		if (info_s4.pass && sat > level_low) begin
			res_nx.edge_value = sat;
			res_nx.edge_class = (sat <= level_high) ? cnms_pkg::CLASS_WEAK
				: cnms_pkg::CLASS_STRONG;
		end
	end

	// Output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res_nx;
		end else if (push) begin
			skid_q <= res_nx;
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_class_matches_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((out_q.edge_class == cnms_pkg::CLASS_NONE) == (out_q.edge_value == 8'd0)))
		else $error("edge class disagrees with edge value");

endmodule

>>> rtl/canny_nms_double_threshold.sv
// Channel  Handshake             Payload
// cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
// pixel    pix_valid/pix_stall   magnitude, direction
// edge     edge_valid/edge_stall pixel_x, pixel_y, edge_value, edge_class, run_last, frame_last
//
// One pixel per cycle while each pixel owes at most one result and edge is not
// stalled; the single result port sets the pace: each pixel on the last row owes
// two results, and each row end owes one or two more.
// Reset clears counters, window and pipeline, sets config defaults; line buffer is not cleared.
// Stalls on edge fill a skid entry, then back up to pix_stall.
module canny_nms_double_threshold #(
	parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF,
	parameter int MAG_BITS  = cnms_pkg::MAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [15:0] magnitude,
	input  logic [2:0]  direction,
	output logic        edge_valid,
	input  logic        edge_stall,
	output logic [9:0]  pixel_x,
	output logic [11:0] pixel_y,
	output logic [7:0]  edge_value,
	output logic [1:0]  edge_class,
	output logic        run_last,
	output logic        frame_last
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int MW = (MAG_BITS < cnms_pkg::MAG_PORT_W) ? MAG_BITS : cnms_pkg::MAG_PORT_W;
	localparam int DW = $bits(cnms_pkg::dir_t);
	localparam int WW = 2 * MW + DW;
	localparam int CW = (XW + 1 > $bits(cnms_pkg::width_t)) ? XW + 1 : $bits(cnms_pkg::width_t);
	localparam int HW = $bits(cnms_pkg::height_t);

	cnms_pkg::width_t     width_q;
	cnms_pkg::height_t    height_q;
	cnms_pkg::scale_t     scale_q;
	cnms_pkg::byte_t      low_q;
	cnms_pkg::byte_t      high_q;

	logic [XW-1:0]        col_q;
	cnms_pkg::py_t        row_q;
	logic [CW-1:0]        width_c;
	cnms_pkg::height_t    height_c;
	logic                 row_end;
	logic                 last_row;
	logic                 acc;

	logic                 s1_v;
	logic [XW-1:0]        xa_s1;
	cnms_pkg::pos_t       pos_s1;
	logic [MW-1:0]        m_s1;
	cnms_pkg::dir_t       d_s1;
	logic                 s1_adv;

	logic [WW-1:0]        word_s1;
	logic [WW-1:0]        new_word;
	logic [MW-1:0]        bank0;
	logic [MW-1:0]        bank1;
	logic [MW-1:0]        bank_cur;
	logic [MW-1:0]        bank_oth;
	logic [MW-1:0]        top_val;
	logic [MW-1:0]        mid_val;
	cnms_pkg::dir_t       dir_mid;

	logic                 take;
	logic                 cand_valid;
	logic                 cand_ready;
	cnms_pkg::cand_t      cand;
	logic [MW-1:0]        cand_mag;
	cnms_pkg::result_t    res;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cnms_pkg::WIDTH_RST;
			height_q <= cnms_pkg::HEIGHT_RST;
			scale_q  <= cnms_pkg::SCALE_RST;
			low_q    <= cnms_pkg::LOW_RST;
			high_q   <= cnms_pkg::HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cnms_pkg::cfg_idx_t'(cfg_index))
				cnms_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[$bits(cnms_pkg::width_t)-1:0];
				cnms_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[HW-1:0];
				cnms_pkg::CFG_NORM_SCALE:   scale_q  <= cfg_data[cnms_pkg::SCALE_W-1:0];
				cnms_pkg::CFG_LEVEL_LOW:    low_q    <= cfg_data[7:0];
				cnms_pkg::CFG_LEVEL_HIGH:   high_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Clamp the frame geometry and find row and frame ends
	always_comb begin
		if (width_q == '0) begin
			width_c = CW'(1);
		end else if (CW'(width_q) > CW'(MAX_WIDTH)) begin
			width_c = CW'(MAX_WIDTH);
		end else begin
			width_c = CW'(width_q);
		end
		if (height_q == '0) begin
			height_c = HW'(1);
		end else if (height_q > HW'(cnms_pkg::MAX_HEIGHT)) begin
			height_c = HW'(cnms_pkg::MAX_HEIGHT);
		end else begin
			height_c = height_q;
		end
		row_end  = (CW'(col_q) + CW'(1)) >= width_c;
		last_row = (HW'(row_q) + HW'(1)) >= height_c;
	end

	assign s1_adv    = s1_v && take;
	assign pix_stall = s1_v && !take;
	assign acc       = pix_valid && !pix_stall;

	// Advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// Stage 1 holds the pixel while its column entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= acc || (s1_v && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			xa_s1           <= col_q;
			pos_s1.x        <= cnms_pkg::px_t'(col_q);
			pos_s1.y        <= row_q;
			pos_s1.x_is0    <= col_q == '0;
			pos_s1.x_is1    <= col_q == XW'(1);
			pos_s1.y_is0    <= row_q == '0;
			pos_s1.y_is1    <= row_q == 12'd1;
			pos_s1.row_end  <= row_end;
			pos_s1.last_row <= last_row;
			m_s1            <= magnitude[MW-1:0];
			d_s1            <= direction;
		end
	end

	cnms_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (XW),
		.WW    (WW)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (col_q),
		.wr_en   (s1_adv),
		.wr_addr (xa_s1),
		.wr_data (new_word),
		.rd_data (word_s1)
	);

	// Split the column entry; row y-2 sits in bank y mod 2, row y-1 in the other
	always_comb begin
		bank0    = word_s1[MW-1:0];
		bank1    = word_s1[2*MW-1:MW];
		bank_cur = pos_s1.y[0] ? bank1 : bank0;
		bank_oth = pos_s1.y[0] ? bank0 : bank1;
		top_val  = (!pos_s1.y_is0 && !pos_s1.y_is1) ? bank_cur : '0;
		mid_val  = !pos_s1.y_is0 ? bank_oth : '0;
		dir_mid  = !pos_s1.y_is0 ? word_s1[WW-1:2*MW] : '0;
		new_word = {d_s1, pos_s1.y[0] ? m_s1 : bank1, pos_s1.y[0] ? bank0 : m_s1};
	end

	cnms_window #(
		.MW (MW)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s1_adv),
		.pos        (pos_s1),
		.top_val    (top_val),
		.mid_val    (mid_val),
		.bot_val    (m_s1),
		.dir_mid    (dir_mid),
		.dir_bot    (d_s1),
		.take       (take),
		.cand_ready (cand_ready),
		.cand_valid (cand_valid),
		.cand       (cand),
		.cand_mag   (cand_mag)
	);

	cnms_classify #(
		.MW (MW)
	) u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.norm_scale (scale_q),
		.level_low  (low_q),
		.level_high (high_q),
		.cand_valid (cand_valid),
		.cand       (cand),
		.cand_mag   (cand_mag),
		.cand_ready (cand_ready),
		.res_valid  (edge_valid),
		.res_stall  (edge_stall),
		.res        (res)
	);

	assign pixel_x    = res.pixel_x;
	assign pixel_y    = res.pixel_y;
	assign edge_value = res.edge_value;
	assign edge_class = res.edge_class;
	assign run_last   = res.run_last;
	assign frame_last = res.frame_last;

	a_stall_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> s1_v)
		else $error("pixel stalled with stage 1 empty");

endmodule
